// ===== hdl/lifo_stack_with_depth_peek_assert.svh =====
// ----------------------------------------------------------------------------
// lifo_stack_with_depth_peek_assert.svh
// Assertion macros for the checker file of the stack block.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_DEPTH_PEEK_ASSERT_SVH
`define LIFO_STACK_WITH_DEPTH_PEEK_ASSERT_SVH

// Generic clocked property, disabled while reset is high.
`define LSDP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal must hold on the cycle after the condition.
`define LSDP_ASSERT_HOLD(lbl, clk, rst, cond, sig, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

// ===== hdl/lsdp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsdp_pkg
// Sizes, codes and shared types of the LIFO stack with depth peek.
// ----------------------------------------------------------------------------
package lsdp_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int ELEMENT_WIDTH = 32;

   // fixed field widths of the channels
   localparam int DATA_W  = 32;
   localparam int KIND_W  = 2;
   localparam int DIDX_W  = 6;
   localparam int STAT_W  = 2;
   localparam int FILL_W  = 7;

   localparam int IDX_W   = $clog2(STACK_DEPTH);
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

   // OR tree grouping for the read path
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (STACK_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_DEPTH = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_MERGE
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic    push;     // shift towards the bottom, new element at the top
      logic    pop;      // shift towards the top
      logic    capture;  // load the read tap
      logic    rd_en;    // a read is wanted
      idx_type rd_idx;   // cell to read, 0 is the top
   } cell_ctrl_type;

endpackage

// ===== hdl/lsdp_if.sv =====
// ----------------------------------------------------------------------------
// lsdp_req_if / lsdp_rsp_if
// Valid/ready channels for requests and results of the stack.
// ----------------------------------------------------------------------------
interface lsdp_req_if import lsdp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [DATA_W-1:0] push_value;
   logic [DIDX_W-1:0] depth_index;

   modport source (output valid, kind, push_value, depth_index, input ready);
   modport sink   (input valid, kind, push_value, depth_index, output ready);
endinterface

interface lsdp_rsp_if import lsdp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_value;
   logic [STAT_W-1:0] status;
   logic [FILL_W-1:0] fill_count;
   logic              is_empty;

   modport source (output valid, read_value, status, fill_count, is_empty, input ready);
   modport sink   (input valid, read_value, status, fill_count, is_empty, output ready);
endinterface

// ===== hdl/lsdp_cell.sv =====
// ----------------------------------------------------------------------------
// lsdp_cell
// One stack slot: shifts with its neighbours on push/pop, offers a read tap.
// ----------------------------------------------------------------------------
module lsdp_cell import lsdp_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  idx_type       cell_idx,
   input  elem_type      above,
   input  elem_type      below,
   output elem_type      data,
   output elem_type      tap
);

   elem_type data_ff, data_in;
   elem_type tap_ff, tap_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.push) begin
         data_in = above;
      end else if (ctrl.pop) begin
         data_in = below;
      end
   end

   // tap sees the value before this transaction's shift
   always_comb begin
      tap_in = tap_ff;
      if (ctrl.capture) begin
         tap_in = (ctrl.rd_en && (ctrl.rd_idx == cell_idx)) ? data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data = data_ff;
   assign tap  = tap_ff;

endmodule

// ===== hdl/lsdp_merge.sv =====
// ----------------------------------------------------------------------------
// lsdp_merge
// Registered OR tree collecting the single live tap of the cell chain.
// ----------------------------------------------------------------------------
module lsdp_merge import lsdp_pkg::*; (
   input  logic     clock,
   input  elem_type taps [STACK_DEPTH],
   output elem_type merged
);

   elem_type group_ff [NUM_GROUPS];
   elem_type group_in [NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < STACK_DEPTH) begin
               group_in[g] = group_in[g] | taps[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      merged = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         merged = merged | group_ff[g];
      end
   end

endmodule

// ===== hdl/lifo_stack_with_depth_peek.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_depth_peek
// Fixed-depth LIFO held in a chain of shifting cells, with push, pop, peek at
// the top and peek at a given depth below the top.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | kind, push_value, depth_index
//  rsp     | out | valid / ready | read_value, status, fill_count, is_empty
//
//  After acceptance a result is registered in the cell taps at capture, then
//  in the registered group stage of the OR read tree, whose last level feeds
//  the output register. The stack shifts in the acceptance cycle; the next
//  request is taken once the result has moved into the output register,
//  which may still be waiting. A stalled result holds the block in its merge
//  step. Synchronous reset empties the stack; cell contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_depth_peek import lsdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lsdp_req_if.sink   req,
   lsdp_rsp_if.source rsp
);

   state_type     state_ff, state_in;
   cnt_type       count_ff, count_in;
   status_type    pend_status_ff, pend_status_in;
   cnt_type       pend_count_ff, pend_count_in;
   cell_ctrl_type cell_ctrl;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   cnt_type           rsp_count_ff, rsp_count_in;

   elem_type cell_data [STACK_DEPTH];
   elem_type cell_tap  [STACK_DEPTH];
   elem_type merged;
   elem_type push_elem;

   logic     accept;
   kind_type kind;
   logic     is_full, is_zero, beyond;

   assign kind      = kind_type'(req.kind);
   assign push_elem = elem_type'(req.push_value);
   assign is_full   = (count_ff == cnt_type'(STACK_DEPTH));
   assign is_zero   = (count_ff == '0);
   assign beyond    = (32'(req.depth_index) >= 32'(count_ff));

   // request decode and stack update
   always_comb begin
      cell_ctrl      = '0;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      if (accept) begin
         cell_ctrl.capture = 1'b1;
         pend_status_in    = STAT_OK;
         unique case (kind)
            KIND_PUSH: begin
               if (is_full) begin
                  pend_status_in = STAT_FULL;
               end else begin
                  cell_ctrl.push = 1'b1;
                  count_in       = count_ff + cnt_type'(1);
               end
            end
            KIND_POP: begin
               if (is_zero) begin
                  pend_status_in = STAT_EMPTY;
               end else begin
                  cell_ctrl.pop   = 1'b1;
                  cell_ctrl.rd_en = 1'b1;
                  count_in        = count_ff - cnt_type'(1);
               end
            end
            KIND_PEEK: begin
               if (is_zero) begin
                  pend_status_in = STAT_EMPTY;
               end else begin
                  cell_ctrl.rd_en = 1'b1;
               end
            end
            KIND_DEPTH: begin
               if (is_zero) begin
                  pend_status_in = STAT_EMPTY;
               end else if (beyond) begin
                  pend_status_in = STAT_RANGE;
               end else begin
                  cell_ctrl.rd_en  = 1'b1;
                  cell_ctrl.rd_idx = idx_type'(req.depth_index);
               end
            end
            default: begin
               pend_status_in = STAT_OK;
            end
         endcase
         pend_count_in = count_in;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req.ready     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = DATA_W'(merged);
               rsp_status_in = pend_status_ff;
               rsp_count_in  = pend_count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // cell chain, cell 0 is the top of the stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      elem_type above, below;
      if (i == 0) begin : g_top
         assign above = push_elem;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign below = '0;
      end else begin : g_up
         assign below = cell_data[i+1];
      end
      lsdp_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .cell_idx (idx_type'(i)),
         .above    (above),
         .below    (below),
         .data     (cell_data[i]),
         .tap      (cell_tap[i])
      );
   end

   lsdp_merge u_merge (
      .clock  (clock),
      .taps   (cell_tap),
      .merged (merged)
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = rsp_value_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.fill_count = FILL_W'(rsp_count_ff);
   assign rsp.is_empty   = (rsp_count_ff == '0);

endmodule

// ===== hdl/lsdp_checker.sv =====
// ----------------------------------------------------------------------------
// lsdp_checker
// Port-level checks on the stack's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_depth_peek_assert.svh"

module lsdp_checker import lsdp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_value,
   input logic [STAT_W-1:0] rsp_status,
   input logic [FILL_W-1:0] rsp_fill_count,
   input logic              rsp_is_empty
);

   logic [DATA_W+STAT_W+FILL_W:0] rsp_payload;
   assign rsp_payload = {rsp_read_value, rsp_status, rsp_fill_count, rsp_is_empty};

   `LSDP_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, {rsp_valid, rsp_payload}, "stalled result transaction changed")
   `LSDP_ASSERT(a_empty_flag, clock, reset, rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)), "empty flag disagrees with fill count")
   `LSDP_ASSERT(a_fill_bound, clock, reset, rsp_valid |-> (32'(rsp_fill_count) <= STACK_DEPTH), "fill count beyond stack depth")
   `LSDP_ASSERT(a_err_zero, clock, reset, (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_read_value == '0), "failed transaction returned data")

endmodule

bind lifo_stack_with_depth_peek lsdp_checker u_lsdp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_read_value (rsp.read_value),
   .rsp_status     (rsp.status),
   .rsp_fill_count (rsp.fill_count),
   .rsp_is_empty   (rsp.is_empty)
);

// ===== verif/tb_lifo_stack_with_depth_peek.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_depth_peek
// Drives push, pop, top peek and depth peek transactions into the stack.
// Each result is compared field by field against a behavioural copy of the
// stack, or against the literal result of a typed directed row. A short
// directed table comes first, then random runs biased to fill, drain and
// overflow the stack, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_depth_peek import lsdp_pkg::*;;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 750;
   localparam int TAIL_CYCLES    = 10;
   localparam int NUM_DIRECTED   = 24;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      status_type        status;
      logic [FILL_W-1:0] fill_count;
      logic              is_empty;
   } stack_result_type;

   typedef struct packed {
      kind_type          op;
      logic [DATA_W-1:0] value;
      logic [DIDX_W-1:0] depth_sel;
      logic              typed;
      stack_result_type  rsp;
   } directed_row_type;

   typedef enum {SEG_CLIMB, SEG_FILL, SEG_DRAIN, SEG_MIX} segment_type;
   typedef enum {RX_STREAM, RX_PATTERN, RX_RANDOM} rx_mode_type;

   localparam stack_result_type UNTYPED = '{32'h0, STAT_OK, 7'd0, 1'b0};

   // typed rows hold results that follow directly from reset and the extremes
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{KIND_POP,   32'h0000_0000, 6'd0,  1'b1, '{32'h0000_0000, STAT_EMPTY, 7'd0, 1'b1}},
      '{KIND_PEEK,  32'hFFFF_FFFF, 6'd63, 1'b1, '{32'h0000_0000, STAT_EMPTY, 7'd0, 1'b1}},
      '{KIND_DEPTH, 32'h0000_0000, 6'd0,  1'b1, '{32'h0000_0000, STAT_EMPTY, 7'd0, 1'b1}},
      '{KIND_DEPTH, 32'h0000_0000, 6'd63, 1'b1, '{32'h0000_0000, STAT_EMPTY, 7'd0, 1'b1}},
      '{KIND_PUSH,  32'h0000_0000, 6'd63, 1'b1, '{32'h0000_0000, STAT_OK,    7'd1, 1'b0}},
      '{KIND_PUSH,  32'hFFFF_FFFF, 6'd0,  1'b1, '{32'h0000_0000, STAT_OK,    7'd2, 1'b0}},
      '{KIND_PEEK,  32'h0000_0000, 6'd0,  1'b1, '{32'hFFFF_FFFF, STAT_OK,    7'd2, 1'b0}},
      '{KIND_DEPTH, 32'h0000_0000, 6'd0,  1'b1, '{32'hFFFF_FFFF, STAT_OK,    7'd2, 1'b0}},
      '{KIND_DEPTH, 32'h0000_0000, 6'd1,  1'b1, '{32'h0000_0000, STAT_OK,    7'd2, 1'b0}},
      '{KIND_DEPTH, 32'h0000_0000, 6'd2,  1'b1, '{32'h0000_0000, STAT_RANGE, 7'd2, 1'b0}},
      '{KIND_DEPTH, 32'hFFFF_FFFF, 6'd63, 1'b1, '{32'h0000_0000, STAT_RANGE, 7'd2, 1'b0}},
      '{KIND_PUSH,  32'hA5A5_5A5A, 6'h2A, 1'b0, UNTYPED},
      '{KIND_PUSH,  32'h8000_0001, 6'h15, 1'b0, UNTYPED},
      '{KIND_DEPTH, 32'h0000_0000, 6'd3,  1'b0, UNTYPED},
      '{KIND_DEPTH, 32'h0000_0000, 6'd2,  1'b0, UNTYPED},
      '{KIND_POP,   32'h0000_0000, 6'd0,  1'b0, UNTYPED},
      '{KIND_POP,   32'h0000_0000, 6'd0,  1'b0, UNTYPED},
      '{KIND_POP,   32'h0000_0000, 6'd0,  1'b1, '{32'hFFFF_FFFF, STAT_OK,    7'd1, 1'b0}},
      '{KIND_POP,   32'h0000_0000, 6'd0,  1'b1, '{32'h0000_0000, STAT_OK,    7'd0, 1'b1}},
      '{KIND_POP,   32'h0000_0000, 6'd0,  1'b1, '{32'h0000_0000, STAT_EMPTY, 7'd0, 1'b1}},
      '{KIND_PUSH,  32'h0000_0001, 6'd0,  1'b0, UNTYPED},
      '{KIND_PUSH,  32'h7FFF_FFFF, 6'd0,  1'b0, UNTYPED},
      '{KIND_POP,   32'hFFFF_FFFF, 6'd63, 1'b0, UNTYPED},
      '{KIND_PEEK,  32'h0000_0000, 6'd0,  1'b0, UNTYPED}
   };

   logic clock;
   logic reset;

   lsdp_req_if req_bus ();
   lsdp_rsp_if rsp_bus ();

   lifo_stack_with_depth_peek dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // behavioural stack
   elem_type         held_values [STACK_DEPTH];
   int               held_count;
   stack_result_type pending_results [$];

   // typed expectation travelling with the transaction on the bus
   logic             typed_check;
   stack_result_type typed_rsp;

   int               mismatch_count;
   int               idle_cycles;
   int               burst_left;
   int               random_sent;

   rx_mode_type      rx_mode;
   int               rx_phase;
   logic [15:0]      rx_pattern;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic stack_result_type stack_apply(kind_type op, logic [DATA_W-1:0] value,
                                                    logic [DIDX_W-1:0] depth_sel);
      stack_result_type r;
      r.read_value = '0;
      r.status     = STAT_OK;
      case (op)
         KIND_PUSH: begin
            if (held_count >= STACK_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               held_values[held_count] = value[ELEMENT_WIDTH-1:0];
               held_count++;
            end
         end
         KIND_POP: begin
            if (held_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               held_count--;
               r.read_value = DATA_W'(held_values[held_count]);
            end
         end
         KIND_PEEK: begin
            if (held_count == 0) r.status = STAT_EMPTY;
            else r.read_value = DATA_W'(held_values[held_count - 1]);
         end
         default: begin
            if (held_count == 0) r.status = STAT_EMPTY;
            else if (int'(depth_sel) >= held_count) r.status = STAT_RANGE;
            else r.read_value = DATA_W'(held_values[held_count - 1 - int'(depth_sel)]);
         end
      endcase
      r.fill_count = FILL_W'(held_count);
      r.is_empty   = (held_count == 0);
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   function automatic logic [DIDX_W-1:0] pick_depth();
      // mostly legal distances, so that deep entries really get read back
      if (held_count > 0 && $urandom_range(0, 3) != 0)
         return DIDX_W'($urandom_range(0, held_count - 1));
      return DIDX_W'($urandom_range(0, 63));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(kind_type op, logic [DATA_W-1:0] value,
                            logic [DIDX_W-1:0] depth_sel,
                            logic typed, stack_result_type lit);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= op;
      req_bus.push_value  <= value;
      req_bus.depth_index <= depth_sel;
      typed_check         <= typed;
      typed_rsp           <= lit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: alternates between streaming, a rotating pattern and random stalls
   always @(negedge clock) begin
      if (rx_phase == 0) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 2));
         rx_pattern = 16'($urandom);
         rx_phase   = $urandom_range(16, 96);
      end
      rx_phase--;
      case (rx_mode)
         RX_STREAM: rsp_bus.ready <= 1'b1;
         RX_PATTERN: begin
            rsp_bus.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
         end
         default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      stack_result_type want;
      stack_result_type predicted;
      logic             moved;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               $error("result transaction with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.read_value !== want.read_value) begin
                  $error("read_value: expected %h, got %h", want.read_value, rsp_bus.read_value);
                  mismatch_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  mismatch_count++;
               end
               if (rsp_bus.fill_count !== want.fill_count) begin
                  $error("fill_count: expected %0d, got %0d", want.fill_count,
                         rsp_bus.fill_count);
                  mismatch_count++;
               end
               if (rsp_bus.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %b, got %b", want.is_empty, rsp_bus.is_empty);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            predicted = stack_apply(kind_type'(req_bus.kind), req_bus.push_value,
                                    req_bus.depth_index);
            pending_results.push_back(typed_check ? typed_rsp : predicted);
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      segment_type seg;
      kind_type    op;
      int          seg_len;
      int          roll;
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_PUSH;
      req_bus.push_value  = '0;
      req_bus.depth_index = '0;
      rsp_bus.ready       = 1'b0;
      typed_check         = 1'b0;
      typed_rsp           = UNTYPED;
      held_count          = 0;
      mismatch_count      = 0;
      idle_cycles         = 0;
      burst_left          = 0;
      random_sent         = 0;
      rx_mode             = RX_STREAM;
      rx_phase            = 0;
      rx_pattern          = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].depth_sel,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

      seg = SEG_CLIMB;
      while (random_sent < RANDOM_ITEMS) begin
         if (seg == SEG_CLIMB) begin
            // run up to full, knock on the lid, then read from the bottom and at random depths
            while (held_count < STACK_DEPTH) begin
               send_item(KIND_PUSH, pick_value(), DIDX_W'($urandom), 1'b0, UNTYPED);
               random_sent++;
            end
            repeat ($urandom_range(1, 4)) begin
               send_item(KIND_PUSH, pick_value(), DIDX_W'($urandom), 1'b0, UNTYPED);
               random_sent++;
            end
            send_item(KIND_DEPTH, pick_value(), 6'd63, 1'b0, UNTYPED);
            repeat ($urandom_range(2, 8)) begin
               send_item(KIND_DEPTH, pick_value(), pick_depth(), 1'b0, UNTYPED);
               random_sent++;
            end
            random_sent++;
         end else begin
            seg_len = $urandom_range(8, 40);
            repeat (seg_len) begin
               roll = $urandom_range(0, 99);
               case (seg)
                  SEG_FILL:  op = roll < 70 ? KIND_PUSH : roll < 80 ? KIND_POP :
                                  roll < 90 ? KIND_PEEK : KIND_DEPTH;
                  SEG_DRAIN: op = roll < 15 ? KIND_PUSH : roll < 70 ? KIND_POP :
                                  roll < 85 ? KIND_PEEK : KIND_DEPTH;
                  default:   op = kind_type'(roll % 4);
               endcase
               send_item(op, pick_value(), pick_depth(), 1'b0, UNTYPED);
               random_sent++;
            end
         end
         roll = $urandom_range(0, 7);
         seg  = roll == 0 ? SEG_CLIMB : roll < 3 ? SEG_FILL : roll < 6 ? SEG_DRAIN : SEG_MIX;
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
